// ----- rtl/sample_mean_sd_covariance_macros.svh -----
// Assertion macros shared by the sample statistics RTL.
`ifndef SAMPLE_MEAN_SD_COVARIANCE_MACROS_SVH
`define SAMPLE_MEAN_SD_COVARIANCE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SMSC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SMSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/smsc_pkg.sv -----
// Shared constants, types and width helpers for the sample statistics block.
package smsc_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MEAN_W = 24;
  localparam int unsigned SD_W = 24;
  localparam int unsigned COV_W = 40;
  localparam int unsigned COUNT_W = 11;

  localparam int unsigned MEAN_SHIFT = 8;
  localparam int unsigned VAR_SHIFT = 16;
  localparam int unsigned COV_SHIFT = 8;

  localparam int unsigned ROOT_IN_W = 48;
  localparam int unsigned ROOT_STEPS = ROOT_IN_W / 2;

  localparam int unsigned IN_TDATA_W = 2 * SAMPLE_W;
  localparam int unsigned OUT_FIELDS_W = 2 * MEAN_W + 2 * SD_W + COV_W + COUNT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [2:0] {
    JOB_MEAN_X,
    JOB_MEAN_Y,
    JOB_SD_X,
    JOB_SD_Y,
    JOB_COV
  } job_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_PRODUCT,
    ST_DIFF,
    ST_DIVIDE,
    ST_ROOT,
    ST_STORE,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    logic full;
    logic almost_full;
    logic empty;
  } queue_status_t;

  function automatic int unsigned cnt_width(int unsigned max_samples);
    return $clog2(max_samples + 1);
  endfunction

  function automatic int unsigned snap_width(int unsigned max_samples);
    int unsigned cw;
    cw = cnt_width(max_samples);
    return 1 + cw + 2 * (SAMPLE_W + cw) + 3 * (2 * SAMPLE_W + cw);
  endfunction

endpackage

// ----- rtl/sample_mean_sd_covariance.sv -----
// Top level of the paired-sample mean, standard deviation and covariance unit.
// Pairs are accepted one per cycle while input is not stalled; a set's sums are pushed into
// the queue in the cycle after its last pair is accepted. The result is computed by the
// one-bit-per-cycle divider (five divisions) and the 24-step square root.
// Two sets fit in the queue; input stalls while it is full or one waits with a second on its way.
// Reset is asynchronous and active low; it clears counts, sums, the queue and the output valid.
`include "sample_mean_sd_covariance_macros.svh"

module sample_mean_sd_covariance #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] sample_x, [31:16] sample_y
  input  logic [smsc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [23:0] mean_x, [47:24] mean_y, [71:48] sd_x, [95:72] sd_y, [135:96] cov_xy,
  // [146:136] count, [151:147] zero
  output logic [smsc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [0] overflow
  output logic                               m_axis_tuser
);
  import smsc_pkg::*;

  localparam int unsigned SNAP_W = snap_width(MAX_SAMPLES);
  localparam int unsigned COUNT_LSB = 2 * MEAN_W + 2 * SD_W + COV_W;
  localparam logic [COUNT_W-1:0] CountMax = COUNT_W'(MAX_SAMPLES);

  logic signed [SAMPLE_W-1:0] sample_x;
  logic signed [SAMPLE_W-1:0] sample_y;
  queue_status_t      q_status;
  logic               q_push;
  logic               q_pop;
  logic [SNAP_W-1:0]  q_push_data;
  logic [SNAP_W-1:0]  q_pop_data;
  logic               out_ovf;
  logic [COUNT_W-1:0] out_count;

  assign sample_x = s_axis_tdata[SAMPLE_W-1:0];
  assign sample_y = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];

  smsc_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_x_i     (sample_x),
    .in_y_i     (sample_y),
    .in_last_i  (s_axis_tlast),
    .q_status_i (q_status),
    .push_o     (q_push),
    .snap_o     (q_push_data)
  );

  smsc_fifo #(
    .DW(SNAP_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .status_o    (q_status)
  );

  smsc_back #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .snap_i      (q_pop_data),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_ovf_o   (m_axis_tuser)
  );

  assign out_ovf   = m_axis_tvalid && m_axis_tuser;
  assign out_count = m_axis_tdata[COUNT_LSB +: COUNT_W];

  `SMSC_ASSERT_IMPLIES(a_push_has_room, q_push, !q_status.full, "push into a full queue")
  `SMSC_ASSERT_IMPLIES(a_pop_not_empty, q_pop, !q_status.empty, "pop from an empty queue")
  `SMSC_ASSERT_IMPLIES(a_ovf_count_max, out_ovf, out_count == CountMax, "overflow, short count")
  `SMSC_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_status.empty, "queue empty after a push")

endmodule

// ----- rtl/smsc_front.sv -----
// Front end: accepts sample pairs, counts them and accumulates the running sums.
module smsc_front #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic signed [smsc_pkg::SAMPLE_W-1:0]          in_x_i,
  input  logic signed [smsc_pkg::SAMPLE_W-1:0]          in_y_i,
  input  logic                                          in_last_i,
  input  smsc_pkg::queue_status_t                       q_status_i,
  output logic                                          push_o,
  output logic [smsc_pkg::snap_width(MAX_SAMPLES)-1:0]  snap_o
);
  import smsc_pkg::*;

  localparam int unsigned CW = cnt_width(MAX_SAMPLES);
  localparam int unsigned SW = SAMPLE_W + CW;
  localparam int unsigned PW = 2 * SAMPLE_W;
  localparam int unsigned QW = PW + CW;
  localparam logic [CW-1:0] CountMax = CW'(MAX_SAMPLES);

  logic              accept;
  logic              at_max;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     count_inc;
  logic              ovf_q;
  logic              s1_valid_q;
  logic              s1_last_q;
  logic              s1_keep_q;
  logic              s1_ovf_q;
  logic [CW-1:0]     s1_count_q;
  logic signed [SAMPLE_W-1:0] s1_x_q;
  logic signed [SAMPLE_W-1:0] s1_y_q;
  logic signed [PW-1:0] s1_xx_q;
  logic signed [PW-1:0] s1_yy_q;
  logic signed [PW-1:0] s1_xy_q;
  logic signed [SW-1:0] sum_x_q, sum_x_d;
  logic signed [SW-1:0] sum_y_q, sum_y_d;
  logic signed [QW-1:0] sum_xx_q, sum_xx_d;
  logic signed [QW-1:0] sum_yy_q, sum_yy_d;
  logic signed [QW-1:0] sum_xy_q, sum_xy_d;

  assign in_ready_o = !q_status_i.full &&
                      !(s1_valid_q && s1_last_q && q_status_i.almost_full);
  assign accept     = in_valid_i && in_ready_o;
  assign at_max     = (count_q == CountMax);
  assign count_inc  = at_max ? count_q : count_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ovf_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        count_q <= in_last_i ? '0 : count_inc;
        ovf_q   <= in_last_i ? 1'b0 : (ovf_q | at_max);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q  <= in_last_i;
      s1_keep_q  <= !at_max;
      s1_ovf_q   <= ovf_q | at_max;
      s1_count_q <= count_inc;
      s1_x_q     <= in_x_i;
      s1_y_q     <= in_y_i;
      s1_xx_q    <= PW'(in_x_i) * PW'(in_x_i);
      s1_yy_q    <= PW'(in_y_i) * PW'(in_y_i);
      s1_xy_q    <= PW'(in_x_i) * PW'(in_y_i);
    end
  end

  always_comb begin
    sum_x_d  = sum_x_q;
    sum_y_d  = sum_y_q;
    sum_xx_d = sum_xx_q;
    sum_yy_d = sum_yy_q;
    sum_xy_d = sum_xy_q;
    if (s1_keep_q) begin
      sum_x_d  = sum_x_q + SW'(s1_x_q);
      sum_y_d  = sum_y_q + SW'(s1_y_q);
      sum_xx_d = sum_xx_q + QW'(s1_xx_q);
      sum_yy_d = sum_yy_q + QW'(s1_yy_q);
      sum_xy_d = sum_xy_q + QW'(s1_xy_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xx_q <= '0;
      sum_yy_q <= '0;
      sum_xy_q <= '0;
    end else if (s1_valid_q) begin
      if (s1_last_q) begin
        sum_x_q  <= '0;
        sum_y_q  <= '0;
        sum_xx_q <= '0;
        sum_yy_q <= '0;
        sum_xy_q <= '0;
      end else begin
        sum_x_q  <= sum_x_d;
        sum_y_q  <= sum_y_d;
        sum_xx_q <= sum_xx_d;
        sum_yy_q <= sum_yy_d;
        sum_xy_q <= sum_xy_d;
      end
    end
  end

  assign push_o = s1_valid_q && s1_last_q;
  assign snap_o = {s1_ovf_q, s1_count_q, sum_xy_d, sum_yy_d, sum_xx_d, sum_y_d, sum_x_d};

endmodule

// ----- rtl/smsc_fifo.sv -----
// Two-entry queue of finished set totals between the front and back ends.
module smsc_fifo #(
  parameter int unsigned DW = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [DW-1:0]           push_data_i,
  input  logic                    pop_i,
  output logic [DW-1:0]           pop_data_o,
  output smsc_pkg::queue_status_t status_o
);
  import smsc_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned UW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [UW-1:0] UsedFull = UW'(QUEUE_DEPTH);
  localparam logic [UW-1:0] UsedOne = UW'(1);

  logic [UW-1:0] used_q;
  logic [DW-1:0] head_q;
  logic [DW-1:0] tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      unique case ({push_i, pop_i})
        2'b10:   used_q <= used_q + 1'b1;
        2'b01:   used_q <= used_q - 1'b1;
        default: used_q <= used_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case ({push_i, pop_i})
      2'b10: begin
        if (used_q == '0) begin
          head_q <= push_data_i;
        end else begin
          tail_q <= push_data_i;
        end
      end
      2'b01: begin
        head_q <= tail_q;
      end
      2'b11: begin
        if (used_q == UsedOne) begin
          head_q <= push_data_i;
        end else begin
          head_q <= tail_q;
          tail_q <= push_data_i;
        end
      end
      default: begin
      end
    endcase
  end

  assign pop_data_o           = head_q;
  assign status_o.full        = (used_q == UsedFull);
  assign status_o.almost_full = (used_q >= UW'(QUEUE_DEPTH - 1));
  assign status_o.empty       = (used_q == '0);

endmodule

// ----- rtl/smsc_back.sv -----
// Back end: turns set totals into mean, deviation and covariance with shared units.
module smsc_back #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  smsc_pkg::queue_status_t                       q_status_i,
  input  logic [smsc_pkg::snap_width(MAX_SAMPLES)-1:0]  snap_i,
  output logic                                          pop_o,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output logic [smsc_pkg::OUT_TDATA_W-1:0]              out_data_o,
  output logic                                          out_ovf_o
);
  import smsc_pkg::*;

  localparam int unsigned CW = cnt_width(MAX_SAMPLES);
  localparam int unsigned SW = SAMPLE_W + CW;
  localparam int unsigned PW = 2 * SAMPLE_W;
  localparam int unsigned QW = PW + CW;
  localparam int unsigned PAW = QW + CW + 1;
  localparam int unsigned PBW = 2 * SW;
  localparam int unsigned NW = PAW + 1;
  localparam int unsigned LW = NW + VAR_SHIFT;
  localparam int unsigned DVW = 2 * CW;
  localparam int unsigned RW = ROOT_IN_W;
  localparam int unsigned STEP_W = $clog2(LW + 1);
  localparam logic [STEP_W-1:0] DivLast = STEP_W'(LW - 1);
  localparam logic [STEP_W-1:0] RootLast = STEP_W'(ROOT_STEPS - 1);
  localparam logic [RW-1:0] RootBitInit = {2'b01, {(RW - 2){1'b0}}};

  back_state_e state_q, state_d;
  job_e        job_q, job_next;
  logic [STEP_W-1:0] cnt_q;
  logic        emit;
  logic        is_sd;
  logic        out_valid_q;

  logic              snap_ovf;
  logic [CW-1:0]     snap_n;
  logic signed [SW-1:0] snap_sx, snap_sy;
  logic signed [QW-1:0] snap_sxx, snap_syy, snap_sxy;

  logic              ovf_q;
  logic [CW-1:0]     n_q;
  logic signed [SW-1:0] sx_q, sy_q;
  logic signed [QW-1:0] sxx_q, syy_q, sxy_q;
  logic [DVW-1:0]    nn_q;

  logic signed [QW-1:0]  wide_op;
  logic signed [SW-1:0]  sa, sb;
  logic signed [PAW-1:0] prod_a, pa_q;
  logic signed [PBW-1:0] prod_b, pb_q;

  logic signed [NW-1:0] num_diff, num;
  logic [NW-1:0]     mag;
  logic [LW-1:0]     dividend;
  logic [DVW-1:0]    divisor;

  logic              neg_q;
  logic [DVW-1:0]    dvs_q;
  logic [DVW-1:0]    rem_q, rem_step;
  logic [LW-1:0]     quo_q, quo_step;
  logic [DVW:0]      rem_sh, trial;
  logic              fits;
  logic [LW:0]       q_adj, q_res;

  logic [RW-1:0]     v_q, res_q, bit_q, root_sum;
  logic              root_ge;

  logic [MEAN_W-1:0] mean_x_q, mean_y_q;
  logic [SD_W-1:0]   sd_x_q, sd_y_q;
  logic [COV_W-1:0]  cov_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic              out_ovf_q;

  assign {snap_ovf, snap_n, snap_sxy, snap_syy, snap_sxx, snap_sy, snap_sx} = snap_i;

  assign is_sd = (job_q == JOB_SD_X) || (job_q == JOB_SD_Y);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (!q_status_i.empty) state_d = ST_SQUARE;
      ST_SQUARE:  state_d = ST_PRODUCT;
      ST_PRODUCT: state_d = ST_DIFF;
      ST_DIFF:    state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (cnt_q == DivLast) state_d = is_sd ? ST_ROOT : ST_STORE;
      end
      ST_ROOT:    if (cnt_q == RootLast) state_d = ST_STORE;
      ST_STORE:   state_d = (job_q == JOB_COV) ? ST_EMIT : ST_PRODUCT;
      ST_EMIT:    if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    emit  = 1'b0;
    unique case (state_q)
      ST_IDLE: pop_o = !q_status_i.empty;
      ST_EMIT: emit = !out_valid_q || out_ready_i;
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (job_q)
      JOB_MEAN_X: job_next = JOB_MEAN_Y;
      JOB_MEAN_Y: job_next = JOB_SD_X;
      JOB_SD_X:   job_next = JOB_SD_Y;
      JOB_SD_Y:   job_next = JOB_COV;
      default:    job_next = JOB_MEAN_X;
    endcase
  end

  always_comb begin
    unique case (job_q)
      JOB_SD_X: begin
        wide_op = sxx_q;
        sa      = sx_q;
        sb      = sx_q;
      end
      JOB_SD_Y: begin
        wide_op = syy_q;
        sa      = sy_q;
        sb      = sy_q;
      end
      JOB_COV: begin
        wide_op = sxy_q;
        sa      = sx_q;
        sb      = sy_q;
      end
      default: begin
        wide_op = $signed(QW'(n_q));
        sa      = sx_q;
        sb      = sy_q;
      end
    endcase
  end

  assign prod_a = PAW'($signed({1'b0, n_q})) * PAW'(wide_op);
  assign prod_b = PBW'(sa) * PBW'(sb);

  always_comb begin
    num_diff = NW'(pa_q) - NW'(pb_q);
    unique case (job_q)
      JOB_MEAN_X: begin
        num     = NW'(sx_q);
        divisor = DVW'(n_q);
      end
      JOB_MEAN_Y: begin
        num     = NW'(sy_q);
        divisor = DVW'(n_q);
      end
      JOB_SD_X, JOB_SD_Y, JOB_COV: begin
        num     = num_diff;
        divisor = nn_q;
      end
      default: begin
        num     = NW'(sx_q);
        divisor = DVW'(n_q);
      end
    endcase
    mag = num[NW-1] ? NW'(-num) : NW'(num);
    if (is_sd) begin
      dividend = LW'(mag) << VAR_SHIFT;
    end else if (job_q == JOB_COV) begin
      dividend = LW'(mag) << COV_SHIFT;
    end else begin
      dividend = LW'(mag) << MEAN_SHIFT;
    end
  end

  always_comb begin
    rem_sh   = {rem_q, quo_q[LW-1]};
    trial    = rem_sh - {1'b0, dvs_q};
    fits     = !trial[DVW];
    rem_step = fits ? trial[DVW-1:0] : rem_sh[DVW-1:0];
    quo_step = {quo_q[LW-2:0], fits};
    q_adj    = {1'b0, quo_q} + (LW + 1)'(neg_q && (rem_q != '0));
    q_res    = neg_q ? (~q_adj + 1'b1) : q_adj;
  end

  assign root_sum = res_q + bit_q;
  assign root_ge  = (v_q >= root_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= JOB_MEAN_X;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE:   if (pop_o) job_q <= JOB_MEAN_X;
        ST_DIFF:   cnt_q <= '0;
        ST_DIVIDE: cnt_q <= (cnt_q == DivLast) ? '0 : cnt_q + 1'b1;
        ST_ROOT:   cnt_q <= cnt_q + 1'b1;
        ST_STORE:  job_q <= job_next;
        default: begin
        end
      endcase
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          ovf_q <= snap_ovf;
          n_q   <= snap_n;
          sx_q  <= snap_sx;
          sy_q  <= snap_sy;
          sxx_q <= snap_sxx;
          syy_q <= snap_syy;
          sxy_q <= snap_sxy;
        end
      end
      ST_SQUARE: begin
        nn_q <= prod_a[DVW-1:0];
      end
      ST_PRODUCT: begin
        pa_q <= prod_a;
        pb_q <= prod_b;
      end
      ST_DIFF: begin
        neg_q <= num[NW-1];
        quo_q <= dividend;
        rem_q <= '0;
        dvs_q <= divisor;
      end
      ST_DIVIDE: begin
        quo_q <= quo_step;
        rem_q <= rem_step;
        if (cnt_q == DivLast) begin
          v_q   <= quo_step[RW-1:0];
          res_q <= '0;
          bit_q <= RootBitInit;
        end
      end
      ST_ROOT: begin
        if (root_ge) begin
          v_q   <= v_q - root_sum;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_STORE: begin
        unique case (job_q)
          JOB_MEAN_X: mean_x_q <= q_res[MEAN_W-1:0];
          JOB_MEAN_Y: mean_y_q <= q_res[MEAN_W-1:0];
          JOB_SD_X:   sd_x_q <= res_q[SD_W-1:0];
          JOB_SD_Y:   sd_y_q <= res_q[SD_W-1:0];
          default:    cov_q <= q_res[COV_W-1:0];
        endcase
      end
      ST_EMIT: begin
        if (emit) begin
          out_data_q <= {{OUT_PAD_W{1'b0}}, COUNT_W'(n_q), cov_q, sd_y_q, sd_x_q,
                         mean_y_q, mean_x_q};
          out_ovf_q  <= ovf_q;
        end
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_ovf_o   = out_ovf_q;

endmodule
